// ===== design/mgsf_pkg.sv =====
// package for the multicast group source filter
// types, codes and sizes shared by controller, datapath and top level
package mgsf_pkg;
  localparam int MaxGroups  = 16;
  localparam int MaxSources = 16;
  localparam int GW = $clog2(MaxGroups);
  localparam int SW = $clog2(MaxSources);
  localparam int CW = $clog2(MaxSources + 1);

  typedef enum logic [2:0] {
    F_PACKET = 3'd0, F_JOIN = 3'd1, F_LEAVE = 3'd2, F_ADD = 3'd3,
    F_DEL = 3'd4, F_FLUSH = 3'd5, F_MODE = 3'd6, F_NONE = 3'd7
  } func_t;

  localparam logic [1:0] V_HOST = 2'd0, V_FWD = 2'd1, V_DROP = 2'd2, V_IGMP = 2'd3;
  localparam logic [2:0] S_OK = 3'd0, S_ABSENT = 3'd1, S_NOTMC = 3'd2,
                         S_GFULL = 3'd3, S_SFULL = 3'd4;
  localparam logic [1:0] R_IS_INC = 2'd0, R_IS_EXC = 2'd1, R_TO_INC = 2'd2,
                         R_TO_EXC = 2'd3;

  // input word: operation and packet fields
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] group_addr;
    logic [31:0] source_addr;
    logic        include_mode;
    logic        has_ip_header;
    logic        is_igmp;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] status;
    logic       report_valid;
    logic [1:0] record_type;
    logic [4:0] report_sources;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GSCAN, ST_SRD, ST_SCMP, ST_SHIFT, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture item, clear scan counters
    logic gstep;      // compare one group slot
    logic sread;      // issue source memory read
    logic scmp;       // compare read data
    logic shift;      // move one source down
    logic finish;     // apply update and form result
  } cmd_t;

  typedef struct packed {
    logic gdone;
    logic sdone;
    logic hit;
    logic shdone;
    logic need_src;
    logic need_shift;
  } stat_t;
endpackage

// ===== design/mgsf_if.sv =====
// valid/ready channel carrying one word of payload type
// depends on nothing
interface mgsf_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/mgsf_ctrl.sv =====
// controller state machine for the source filter
// depends on mgsf_pkg
module mgsf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mgsf_pkg::cmd_t cmd,
  input  mgsf_pkg::stat_t st
);
  import mgsf_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_GSCAN;
      ST_GSCAN: if (st.gdone) state_next = st.need_src ? ST_SRD : ST_FIN;
      ST_SRD:   state_next = st.sdone ? (st.need_shift ? ST_SHIFT : ST_FIN) : ST_SCMP;
      ST_SCMP:  state_next = st.hit ? (st.need_shift ? ST_SHIFT : ST_FIN) : ST_SRD;
      ST_SHIFT: if (st.shdone) state_next = ST_FIN;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:  begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_GSCAN: cmd.gstep = 1'b1;
      ST_SRD:   cmd.sread = 1'b1;
      ST_SCMP:  cmd.scmp = 1'b1;
      ST_SHIFT: cmd.shift = 1'b1;
      ST_FIN:   cmd.finish = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end
endmodule

// ===== design/mgsf_dp.sv =====
// datapath: group table, source memory, match scan and result register
// depends on mgsf_pkg
module mgsf_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  mgsf_pkg::cmd_t         cmd,
  output mgsf_pkg::stat_t        st,
  input  logic [2:0]             func,
  input  logic [31:0]            group_addr,
  input  logic [31:0]            source_addr,
  input  logic                   include_mode,
  input  logic                   has_ip_header,
  input  logic                   is_igmp,
  output logic [1:0]             verdict,
  output logic [2:0]             status,
  output logic                   report_valid,
  output logic [1:0]             record_type,
  output logic [4:0]             report_sources
);
  import mgsf_pkg::*;

  logic [MaxGroups-1:0] gvalid;
  logic [31:0]          gaddr [MaxGroups];
  logic                 ginc  [MaxGroups];
  logic [CW-1:0]        gcnt  [MaxGroups];
  logic [31:0]          smem  [MaxGroups*MaxSources];

  func_t       f;
  logic [31:0] ga, sa;
  logic        inc, hdr, igmp;
  logic [GW:0] gi;            // scan index
  logic        gfound, ffound;
  logic [GW-1:0] gsel, gfree;
  logic [CW-1:0] si, cnt;
  logic          sfound;
  logic [SW-1:0] sidx;
  logic [31:0]   rdata;
  logic [GW+SW-1:0] raddr, waddr;
  logic          wpend;       // moved source waits to be written back

  logic mc;
  assign mc = ga[31:28] == 4'hE;

  logic direct;  // items resolved without table search
  assign direct = (f == F_NONE) || ((f == F_JOIN || f == F_LEAVE) && !mc)
               || (f == F_PACKET && (!hdr || igmp || !mc));

  assign st.gdone = direct || gi == (GW+1)'(MaxGroups) || gfound;
  assign st.need_src = gfound && (f == F_PACKET || f == F_ADD || f == F_DEL);
  assign st.sdone = si >= cnt;
  assign st.hit = rdata == sa;
  assign st.need_shift = f == F_DEL;
  assign st.shdone = !sfound || (CW+1)'(sidx) + (CW+1)'(1) >= (CW+1)'(cnt);

  assign raddr = {gsel, si[SW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.sread && !st.sdone) rdata <= smem[raddr];
    if (cmd.shift && !st.shdone) rdata <= smem[{gsel, sidx + SW'(1)}];
    if (cmd.finish && f == F_ADD && gfound && !sfound && cnt < CW'(MaxSources))
      smem[{gsel, cnt[SW-1:0]}] <= sa;
    if (wpend) smem[waddr] <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
      wpend <= 1'b0;
    end else begin
      wpend <= cmd.shift && !st.shdone;
      if (cmd.load) begin
        f <= func_t'(func); ga <= group_addr; sa <= source_addr;
        inc <= include_mode; hdr <= has_ip_header; igmp <= is_igmp;
        gi <= '0; gfound <= 1'b0; ffound <= 1'b0; si <= '0; sfound <= 1'b0;
      end
      if (cmd.gstep && !st.gdone) begin
        if (gvalid[gi[GW-1:0]] && gaddr[gi[GW-1:0]] == ga) begin
          gfound <= 1'b1; gsel <= gi[GW-1:0]; cnt <= gcnt[gi[GW-1:0]];
        end else begin
          if (!gvalid[gi[GW-1:0]] && !ffound) begin
            ffound <= 1'b1; gfree <= gi[GW-1:0];
          end
          gi <= gi + 1'b1;
        end
      end
      if (cmd.sread && !st.sdone) si <= si + 1'b1;
      if (cmd.scmp && st.hit && !sfound) begin
        sfound <= 1'b1; sidx <= SW'(si - CW'(1));
      end
      // delete: rdata holds entry sidx+1, written back at sidx on the next cycle
      if (cmd.shift && !st.shdone) begin
        waddr <= {gsel, sidx};
        sidx <= sidx + SW'(1);
      end
      if (cmd.finish) begin
        verdict <= V_HOST; status <= S_OK; report_valid <= 1'b0;
        record_type <= R_IS_INC; report_sources <= '0;
        unique case (f)
          F_PACKET: begin
            if (igmp && hdr) verdict <= V_IGMP;
            else if (hdr && mc)
              verdict <= (gfound && sfound == ginc[gsel]) ? V_FWD : V_DROP;
          end
          F_JOIN: begin
            if (!mc) status <= S_NOTMC;
            else if (gfound) begin
              ginc[gsel] <= inc; gcnt[gsel] <= '0; report_valid <= 1'b1;
              record_type <= (ginc[gsel] != inc) ? (inc ? R_TO_INC : R_TO_EXC)
                                                 : (inc ? R_IS_INC : R_IS_EXC);
            end else if (!ffound) status <= S_GFULL;
            else begin
              gvalid[gfree] <= 1'b1; gaddr[gfree] <= ga; ginc[gfree] <= inc;
              gcnt[gfree] <= '0; report_valid <= 1'b1;
              record_type <= inc ? R_IS_INC : R_TO_EXC;
            end
          end
          F_LEAVE: begin
            if (!mc) status <= S_NOTMC;
            else if (!gfound) status <= S_ABSENT;
            else begin
              gvalid[gsel] <= 1'b0; report_valid <= 1'b1; record_type <= R_TO_INC;
            end
          end
          F_ADD, F_DEL, F_FLUSH: begin
            if (!gfound) status <= S_ABSENT;
            else if (f == F_ADD && !sfound && cnt >= CW'(MaxSources)) status <= S_SFULL;
            else begin
              report_valid <= 1'b1;
              record_type <= ginc[gsel] ? R_IS_INC : R_IS_EXC;
              if (f == F_FLUSH) begin
                gcnt[gsel] <= '0; report_sources <= '0;
              end else if (f == F_ADD && !sfound) begin
                gcnt[gsel] <= cnt + 1'b1; report_sources <= 5'(cnt + 1'b1);
              end else if (f == F_DEL && sfound) begin
                gcnt[gsel] <= cnt - 1'b1; report_sources <= 5'(cnt - 1'b1);
              end else report_sources <= 5'(cnt);
            end
          end
          F_MODE: begin
            if (!gfound) status <= S_ABSENT;
            else if (ginc[gsel] != inc) begin
              ginc[gsel] <= inc; report_valid <= 1'b1;
              record_type <= inc ? R_TO_INC : R_TO_EXC; report_sources <= 5'(cnt);
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== design/multicast_group_source_filter_core.sv =====
// Source filter for multicast groups: one result word per input word, one item
// at a time. An item passes an accept state, a serial scan of the group table,
// a source scan that alternates a memory read and a compare for each stored
// source, on delete a shift that moves each later source down, a finish state
// and an output state that holds until the result is taken. The serial walk
// over the group table and the one-read-per-cycle source memory set its length.
// depends on mgsf_pkg, mgsf_if, mgsf_ctrl, mgsf_dp
module multicast_group_source_filter_core (
  input logic clk,
  input logic rst,
  mgsf_if.sink   in_ch,
  mgsf_if.source out_ch
);
  import mgsf_pkg::*;
  cmd_t  cmd;
  stat_t st;

  mgsf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .st(st)
  );

  mgsf_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .func(in_ch.data.func), .group_addr(in_ch.data.group_addr),
    .source_addr(in_ch.data.source_addr), .include_mode(in_ch.data.include_mode),
    .has_ip_header(in_ch.data.has_ip_header), .is_igmp(in_ch.data.is_igmp),
    .verdict(out_ch.data.verdict), .status(out_ch.data.status),
    .report_valid(out_ch.data.report_valid), .record_type(out_ch.data.record_type),
    .report_sources(out_ch.data.report_sources)
  );
endmodule
